@@ rtl/sps_pkg.sv @@
// sps_pkg: shared types, constants and codes of the strict priority scheduler
// no dependencies; imported by every module of the block
`default_nettype none
package sps_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int STORE_DEPTH = 1024;
  localparam int TAG_BITS    = 16;
  localparam int MAX_DRAIN   = 64;

  localparam int CLS_W    = 3;
  localparam int IDX_W    = $clog2(STORE_DEPTH);
  localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
  localparam int MAXP_W   = 7;
  localparam int AVG_W    = 16;
  localparam int DEPTH_W  = 11;
  localparam int DIVR_W   = AVG_W + 3;
  localparam int CFG_IDX_W = 4;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;

  localparam logic [AVG_W-1:0]   AVG_RESET   = 16'd1200;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 11'd256;

  localparam logic [CFG_IDX_W-1:0] REG_AVG   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 4'd1;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_BW    = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ENQ   = 3'd0,
    KIND_DROP  = 3'd1,
    KIND_SENT  = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_DONE  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [2:0]          priority_class;
    logic [TAG_BITS-1:0] packet_tag;
    logic                dst_present;
    logic [TAG_BITS-1:0] dst_tag;
    logic [6:0]          drain_max;
    logic [31:0]         rate_target;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [TAG_BITS-1:0] out_tag;
    logic [TAG_BITS-1:0] out_dst;
    logic [2:0]          out_class;
    logic                evicted_valid;
    logic [TAG_BITS-1:0] evicted_tag;
    logic [10:0]         queued_total;
    logic [31:0]         dropped_count;
    logic [31:0]         sent_count;
    logic [63:0]         sent_byte_count;
    logic [31:0]         current_target;
    logic                last;
  } out_item_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [CLS_W-1:0]    cls;
    logic [TAG_BITS-1:0] tag;
    logic                dst_present;
    logic [TAG_BITS-1:0] dst;
    logic [MAXP_W-1:0]   maxp;
    logic [31:0]         target;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/sps_front.sv @@
// sps_front: accepts input transactions, saturates class and drain size,
// and holds them in a two-entry command queue; uses sps_pkg
`default_nettype none
module sps_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire sps_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  output sps_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_pop_i
);
  import sps_pkg::*;

  cmd_t        slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]  count_q, count_d;
  cmd_t        cls_cmd;
  logic        push_ok, pop_ok;
  logic [1:0]  wpos;

  always_comb begin
    cls_cmd.cmd         = cmd_e'(in_item_i.command);
    cls_cmd.cls         = (32'(in_item_i.priority_class) >= NUM_CLASSES) ?
                          CLS_W'(NUM_CLASSES - 1) : in_item_i.priority_class;
    cls_cmd.tag         = in_item_i.packet_tag;
    cls_cmd.dst_present = in_item_i.dst_present;
    cls_cmd.dst         = in_item_i.dst_tag;
    cls_cmd.maxp        = (32'(in_item_i.drain_max) > MAX_DRAIN) ?
                          MAXP_W'(MAX_DRAIN) : in_item_i.drain_max;
    cls_cmd.target      = in_item_i.rate_target;
  end

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot0_q;
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && (count_q != 2'd0);
  assign wpos        = count_q - {1'b0, pop_ok};

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop_ok) begin
      slot0_d = slot1_q;
    end
    if (push_ok) begin
      if (wpos == 2'd0) begin
        slot0_d = cls_cmd;
      end else begin
        slot1_d = cls_cmd;
      end
    end
    count_d = count_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule
`default_nettype wire

@@ rtl/sps_div.sv @@
// sps_div: restoring divider, one quotient bit per cycle, for the packet limit
// uses sps_pkg
`default_nettype none
module sps_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                dividend_i,
  input  wire logic [sps_pkg::DIVR_W-1:0] divisor_i,
  output logic                            busy_o,
  output logic [31:0]                     quot_o
);
  import sps_pkg::*;

  logic [DIVR_W:0]   rem_q, rem_d, rem_sh;
  logic [31:0]       quo_q, quo_d;
  logic [DIVR_W-1:0] dvs_q, dvs_d;
  logic [5:0]        cnt_q, cnt_d;

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quo_q;
  assign rem_sh = {rem_q[DIVR_W-1:0], quo_q[31]};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d    = rem_sh - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = rem_sh;
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule
`default_nettype wire

@@ rtl/sps_outq.sv @@
// sps_outq: four-entry result queue between the back end and the result port
// uses sps_pkg
`default_nettype none
module sps_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire sps_pkg::out_item_t data_i,
  output logic                    full_o,
  input  wire logic               pop,
  output logic                    empty,
  output sps_pkg::out_item_t      out_item_o
);
  import sps_pkg::*;

  out_item_t             mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_q, rd_q;
  logic [OQ_PTR_W:0]     cnt_q;
  logic                  push_ok, pop_ok;

  assign full_o     = (cnt_q == (OQ_PTR_W+1)'(OQ_DEPTH));
  assign empty      = (cnt_q == '0);
  assign push_ok    = push_i && !full_o;
  assign pop_ok     = pop && !empty;
  assign out_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (OQ_PTR_W+1)'(push_ok) - (OQ_PTR_W+1)'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sps_back.sv @@
// sps_back: command executor with the linked packet store, class queues,
// free list, counters and trim sequencer; uses sps_pkg and sps_div
`default_nettype none
module sps_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire sps_pkg::cmd_t               cmd_i,
  output logic                             cmd_pop_o,
  input  wire logic [sps_pkg::AVG_W-1:0]   avg_i,
  input  wire logic [sps_pkg::DEPTH_W-1:0] depth_i,
  output logic                             res_push_o,
  output sps_pkg::out_item_t               res_o,
  input  wire logic                        res_full_i
);
  import sps_pkg::*;

  localparam int DP_W = MAXP_W + AVG_W;
  localparam int QP_W = CNT_W + AVG_W;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_EVICT = 12'b000000000010,
    ST_ALLOC = 12'b000000000100,
    ST_LINK  = 12'b000000001000,
    ST_DSET  = 12'b000000010000,
    ST_DRD   = 12'b000000100000,
    ST_DWR   = 12'b000001000000,
    ST_DIV   = 12'b000010000000,
    ST_TSUM  = 12'b000100000000,
    ST_TCHK  = 12'b001000000000,
    ST_TCUT  = 12'b010000000000,
    ST_EMIT  = 12'b100000000000
  } st_e;

  st_e state_q, state_d;

  logic [IDX_W-1:0] head_q [NUM_CLASSES];
  logic [IDX_W-1:0] head_d [NUM_CLASSES];
  logic [IDX_W-1:0] tail_q [NUM_CLASSES];
  logic [IDX_W-1:0] tail_d [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_d  [NUM_CLASSES];

  logic [CNT_W-1:0]    total_q, total_d, free_cnt_q, free_cnt_d, fresh_q, fresh_d;
  logic [IDX_W-1:0]    free_head_q, free_head_d, node_q, node_d;
  logic [TAG_BITS-1:0] last_dest_q, last_dest_d;
  logic [31:0]         limit_q, limit_d, target_q, target_d;
  logic [31:0]         drop_q, drop_d, sent_q, sent_d;
  logic [63:0]         bytes_q, bytes_d, fin_bytes_q, fin_bytes_d;
  logic [CLS_W-1:0]    cls_q, cls_d, enq_cls_q, enq_cls_d;
  logic [TAG_BITS-1:0] enq_tag_q, enq_tag_d, enq_dst_q, enq_dst_d;
  logic [MAXP_W-1:0]   remain_q, remain_d;
  logic [31:0]         budget_q, budget_d, sum_q, sum_d;
  logic                cut_all_q, cut_all_d, div_used_q, div_used_d;
  logic                ev_q, ev_d;
  logic [TAG_BITS-1:0] evtag_q, evtag_d;
  kind_e               kind_q, kind_d;

  logic [TAG_BITS-1:0] tag_mem  [STORE_DEPTH];
  logic [TAG_BITS-1:0] dst_mem  [STORE_DEPTH];
  logic [IDX_W-1:0]    link_mem [STORE_DEPTH];
  logic [TAG_BITS-1:0] tag_rd_q, dst_rd_q;
  logic [IDX_W-1:0]    link_rd_q;

  logic                rd_en, td_we, link_we;
  logic [IDX_W-1:0]    rd_addr, td_wa, link_wa, link_wd;

  logic [CLS_W-1:0]    ev_cls, dr_cls, cls_sel;
  logic                any_ne;
  logic [IDX_W-1:0]    head_sel, tail_sel;
  logic [CNT_W-1:0]    cnt_sel;
  logic [DEPTH_W-1:0]  limit_depth;
  logic [QP_W-1:0]     qprod;
  logic [DP_W-1:0]     dprod;
  logic [MAXP_W-1:0]   cap, ndrain;
  logic                do_push, do_pop, do_splice;
  logic [IDX_W-1:0]    push_node;
  logic [TAG_BITS-1:0] dst_pick;
  logic                div_start, div_busy;
  logic [31:0]         div_quot;

  sps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.target),
    .divisor_i  ({avg_i, 3'b000}),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // highest-numbered non-empty class for eviction, lowest-numbered for drain
  always_comb begin
    ev_cls = '0;
    dr_cls = '0;
    any_ne = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (cnt_q[i] != '0) begin
        ev_cls = CLS_W'(i);
        any_ne = 1'b1;
      end
    end
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        dr_cls = CLS_W'(i);
      end
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE:          cls_sel = ev_cls;
      ST_DRD:           cls_sel = dr_cls;
      ST_ALLOC, ST_LINK: cls_sel = enq_cls_q;
      default:          cls_sel = cls_q;
    endcase
  end

  assign head_sel    = head_q[cls_sel];
  assign tail_sel    = tail_q[cls_sel];
  assign cnt_sel     = cnt_q[cls_sel];
  assign limit_depth = (32'(depth_i) > STORE_DEPTH) ? DEPTH_W'(STORE_DEPTH) : depth_i;
  assign qprod       = QP_W'(cnt_sel) * QP_W'(avg_i);
  assign dprod       = DP_W'(remain_q) * DP_W'(avg_i);
  assign dst_pick    = cmd_i.dst_present ? cmd_i.dst : last_dest_q;

  always_comb begin
    cap = cmd_i.maxp;
    if (limit_q != 32'd0 && limit_q < 32'(cmd_i.maxp)) begin
      cap = limit_q[MAXP_W-1:0];
    end
    ndrain = (32'(total_q) < 32'(cap)) ? total_q[MAXP_W-1:0] : cap;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    free_cnt_d  = free_cnt_q;
    fresh_d     = fresh_q;
    free_head_d = free_head_q;
    node_d      = node_q;
    last_dest_d = last_dest_q;
    limit_d     = limit_q;
    target_d    = target_q;
    drop_d      = drop_q;
    sent_d      = sent_q;
    bytes_d     = bytes_q;
    fin_bytes_d = fin_bytes_q;
    cls_d       = cls_q;
    enq_cls_d   = enq_cls_q;
    enq_tag_d   = enq_tag_q;
    enq_dst_d   = enq_dst_q;
    remain_d    = remain_q;
    budget_d    = budget_q;
    sum_d       = sum_q;
    cut_all_d   = cut_all_q;
    div_used_d  = div_used_q;
    ev_d        = ev_q;
    evtag_d     = evtag_q;
    kind_d      = kind_q;
    cmd_pop_o   = 1'b0;
    div_start   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_sel;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    do_splice   = 1'b0;
    push_node   = node_q;
    res_push_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          ev_d      = 1'b0;
          evtag_d   = '0;
          case (cmd_i.cmd)
            CMD_ENQ: begin
              last_dest_d = dst_pick;
              enq_tag_d   = cmd_i.tag;
              enq_dst_d   = dst_pick;
              enq_cls_d   = cmd_i.cls;
              if (32'(total_q) >= 32'(limit_depth)) begin
                if (any_ne) begin
                  rd_en   = 1'b1;
                  cls_d   = ev_cls;
                  state_d = ST_EVICT;
                end else begin
                  drop_d  = drop_q + 32'd1;
                  kind_d  = KIND_DROP;
                  state_d = ST_EMIT;
                end
              end else begin
                state_d = ST_ALLOC;
              end
            end
            CMD_DRAIN: begin
              if (ndrain == '0) begin
                kind_d  = KIND_EMPTY;
                state_d = ST_EMIT;
              end else begin
                remain_d = ndrain;
                state_d  = ST_DSET;
              end
            end
            CMD_BW: begin
              target_d   = cmd_i.target;
              limit_d    = 32'd0;
              div_used_d = (cmd_i.target != 32'd0) && (avg_i != '0);
              div_start  = div_used_d;
              state_d    = ST_DIV;
            end
            default: begin
              for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_d[i]  = '0;
                head_d[i] = '0;
                tail_d[i] = '0;
              end
              total_d     = '0;
              free_head_d = '0;
              free_cnt_d  = '0;
              fresh_d     = '0;
              last_dest_d = '0;
              limit_d     = '0;
              target_d    = '0;
              drop_d      = '0;
              sent_d      = '0;
              bytes_d     = '0;
              kind_d      = KIND_DONE;
              state_d     = ST_EMIT;
            end
          endcase
        end
      end
      ST_EVICT: begin
        do_pop  = 1'b1;
        ev_d    = 1'b1;
        evtag_d = tag_rd_q;
        if (32'(total_q) > 32'(limit_depth)) begin
          drop_d  = drop_q + 32'd2;
          kind_d  = KIND_DROP;
          state_d = ST_EMIT;
        end else begin
          drop_d  = drop_q + 32'd1;
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (free_cnt_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = free_head_q;
          node_d  = free_head_q;
          state_d = ST_LINK;
        end else begin
          push_node = fresh_q[IDX_W-1:0];
          fresh_d   = fresh_q + 1'b1;
          do_push   = 1'b1;
          kind_d    = KIND_ENQ;
          state_d   = ST_EMIT;
        end
      end
      ST_LINK: begin
        free_head_d = link_rd_q;
        free_cnt_d  = free_cnt_q - 1'b1;
        push_node   = node_q;
        do_push     = 1'b1;
        kind_d      = KIND_ENQ;
        state_d     = ST_EMIT;
      end
      ST_DSET: begin
        fin_bytes_d = bytes_q + 64'(dprod);
        state_d     = ST_DRD;
      end
      ST_DRD: begin
        rd_en   = 1'b1;
        cls_d   = dr_cls;
        state_d = ST_DWR;
      end
      ST_DWR: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          do_pop     = 1'b1;
          sent_d     = sent_q + 32'd1;
          bytes_d    = bytes_q + 64'(avg_i);
          remain_d   = remain_q - 1'b1;
          state_d    = (remain_q == MAXP_W'(1)) ? ST_IDLE : ST_DRD;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          if (div_used_q) begin
            limit_d = div_quot;
          end
          if (target_q == 32'd0) begin
            cut_all_d = 1'b1;
            cls_d     = CLS_W'(NUM_CLASSES - 1);
            state_d   = ST_TCUT;
          end else begin
            budget_d = {6'd0, target_q[31:6]};
            sum_d    = '0;
            cls_d    = CLS_W'(1);
            state_d  = ST_TSUM;
          end
        end
      end
      ST_TSUM: begin
        sum_d = sum_q + 32'(qprod);
        if (cls_q == CLS_W'(NUM_CLASSES - 1)) begin
          state_d = ST_TCHK;
        end else begin
          cls_d = cls_q + 1'b1;
        end
      end
      ST_TCHK: begin
        if (sum_q > budget_q) begin
          cut_all_d = 1'b0;
          cls_d     = CLS_W'(NUM_CLASSES - 1);
          state_d   = ST_TCUT;
        end else begin
          kind_d  = KIND_DONE;
          state_d = ST_EMIT;
        end
      end
      ST_TCUT: begin
        if (!cut_all_q && 32'(qprod) <= budget_q) begin
          budget_d = budget_q - 32'(qprod);
        end else if (cnt_sel != '0) begin
          do_splice = 1'b1;
        end
        if (cls_q == CLS_W'(1)) begin
          kind_d  = KIND_DONE;
          state_d = ST_EMIT;
        end else begin
          cls_d = cls_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // list updates on the selected class
    link_we = 1'b0;
    link_wa = tail_sel;
    link_wd = free_head_q;
    td_we   = 1'b0;
    td_wa   = push_node;
    if (do_push) begin
      td_we = 1'b1;
      if (cnt_sel == '0) begin
        head_d[cls_sel] = push_node;
      end else begin
        link_we = 1'b1;
        link_wa = tail_sel;
        link_wd = push_node;
      end
      tail_d[cls_sel] = push_node;
      cnt_d[cls_sel]  = cnt_sel + 1'b1;
      total_d         = total_q + 1'b1;
    end
    if (do_pop) begin
      head_d[cls_sel] = link_rd_q;
      cnt_d[cls_sel]  = cnt_sel - 1'b1;
      total_d         = total_q - 1'b1;
      link_we         = 1'b1;
      link_wa         = head_sel;
      link_wd         = free_head_q;
      free_head_d     = head_sel;
      free_cnt_d      = free_cnt_q + 1'b1;
    end
    if (do_splice) begin
      link_we        = 1'b1;
      link_wa        = tail_sel;
      link_wd        = free_head_q;
      free_head_d    = head_sel;
      free_cnt_d     = free_cnt_q + cnt_sel;
      drop_d         = drop_q + 32'(cnt_sel);
      total_d        = total_q - cnt_sel;
      cnt_d[cls_sel] = '0;
    end
  end

  always_comb begin
    res_o.kind            = kind_q;
    res_o.out_tag         = '0;
    res_o.out_dst         = '0;
    res_o.out_class       = '0;
    res_o.evicted_valid   = ev_q;
    res_o.evicted_tag     = evtag_q;
    res_o.queued_total    = 11'(total_q);
    res_o.dropped_count   = drop_q;
    res_o.sent_count      = sent_q;
    res_o.sent_byte_count = bytes_q;
    res_o.current_target  = target_q;
    res_o.last            = 1'b1;
    if (kind_q == KIND_ENQ || kind_q == KIND_DROP) begin
      res_o.out_tag   = enq_tag_q;
      res_o.out_dst   = enq_dst_q;
      res_o.out_class = enq_cls_q;
    end
    if (state_q == ST_DWR) begin
      res_o.kind            = KIND_SENT;
      res_o.out_tag         = tag_rd_q;
      res_o.out_dst         = dst_rd_q;
      res_o.out_class       = cls_q;
      res_o.evicted_valid   = 1'b0;
      res_o.evicted_tag     = '0;
      res_o.queued_total    = 11'(total_q - CNT_W'(remain_q));
      res_o.sent_count      = sent_q + 32'(remain_q);
      res_o.sent_byte_count = fin_bytes_q;
      res_o.last            = (remain_q == MAXP_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (td_we) begin
      tag_mem[td_wa] <= enq_tag_q;
      dst_mem[td_wa] <= enq_dst_q;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (rd_en) begin
      tag_rd_q  <= tag_mem[rd_addr];
      dst_rd_q  <= dst_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q     <= '0;
      free_cnt_q  <= '0;
      fresh_q     <= '0;
      free_head_q <= '0;
      last_dest_q <= '0;
      limit_q     <= '0;
      target_q    <= '0;
      drop_q      <= '0;
      sent_q      <= '0;
      bytes_q     <= '0;
      cls_q       <= '0;
      remain_q    <= '0;
      cut_all_q   <= 1'b0;
      div_used_q  <= 1'b0;
      ev_q        <= 1'b0;
      kind_q      <= KIND_DONE;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      free_cnt_q  <= free_cnt_d;
      fresh_q     <= fresh_d;
      free_head_q <= free_head_d;
      last_dest_q <= last_dest_d;
      limit_q     <= limit_d;
      target_q    <= target_d;
      drop_q      <= drop_d;
      sent_q      <= sent_d;
      bytes_q     <= bytes_d;
      cls_q       <= cls_d;
      remain_q    <= remain_d;
      cut_all_q   <= cut_all_d;
      div_used_q  <= div_used_d;
      ev_q        <= ev_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    fin_bytes_q <= fin_bytes_d;
    enq_cls_q   <= enq_cls_d;
    enq_tag_q   <= enq_tag_d;
    enq_dst_q   <= enq_dst_d;
    budget_q    <= budget_d;
    sum_q       <= sum_d;
    evtag_q     <= evtag_d;
  end

endmodule
`default_nettype wire

@@ rtl/strict_priority_packet_scheduler.sv @@
// strict_priority_packet_scheduler: top level with the configuration registers
// depends on sps_pkg, sps_front, sps_back, sps_div and sps_outq
//
// Commands enter through a queue-like port: a transaction is taken when push is
// high and full is low. Results leave the same way: the oldest result is on
// out_item_o while empty is low and is taken when pop is high. Configuration
// writes (average packet size, depth limit) use cfg_valid_i/cfg_ready_o, which
// is always ready; they are meant for idle periods only.
// A two-entry command queue decouples intake from the executor, and a
// four-entry result queue decouples the executor from the receiver; when the
// receiver stalls the executor holds its current result and waits.
// Steps per command, from take to result push: enqueue ALLOC (LINK when a freed
// node is reused) then EMIT, eviction EVICT first (then EMIT if the incoming
// packet is still dropped), plain drop, empty drain and clear straight to EMIT,
// drain DSET then DRD and DWR per sent packet, bandwidth update the bit-serial
// divider then the per-class trim walk. The executor runs one command at a
// time; the packet store's registered read sets the per-packet drain steps.
// Reset empties all classes and counters and restores the register defaults
// (1200 bytes, depth 256); no store clearing pass is needed.
`default_nettype none
module strict_priority_packet_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire sps_pkg::in_item_t             in_item_i,
  output logic                               empty,
  input  wire logic                          pop,
  output sps_pkg::out_item_t                 out_item_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import sps_pkg::*;

  logic [AVG_W-1:0]   avg_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               cmd_valid, cmd_pop, res_push, res_full;
  cmd_t               cmd;
  out_item_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= AVG_RESET;
      depth_q <= DEPTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_AVG:   avg_q   <= cfg_data_i[AVG_W-1:0];
        REG_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .avg_i       (avg_q),
    .depth_i     (depth_q),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  sps_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .data_i     (res),
    .full_o     (res_full),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

@@ tb/sps_checker.sv @@
// sps_checker: watches the command, result and register channels of the scheduler,
// predicts every result transaction and compares it field by field; uses sps_pkg
`default_nettype none
module sps_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic                          full_i,
  input  wire sps_pkg::in_item_t             in_item_i,
  input  wire logic                          empty_i,
  input  wire logic                          pop_i,
  input  wire sps_pkg::out_item_t            out_item_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  typedef struct {
    logic [TAG_BITS-1:0] tag;
    logic [TAG_BITS-1:0] dst;
  } pkt_t;

  pkt_t               class_q [NUM_CLASSES][$];
  out_item_t          expected_results [$];
  logic [AVG_W-1:0]   avg_bytes;
  logic [DEPTH_W-1:0] depth_limit;
  logic [TAG_BITS-1:0] last_dst;
  logic [31:0]        pkt_limit;
  logic [31:0]        target_rate;
  logic [31:0]        drop_total;
  logic [31:0]        send_total;
  logic [63:0]        byte_total;

  function automatic int queued_sum();
    int s;
    s = 0;
    for (int c = 0; c < NUM_CLASSES; c++) s += class_q[c].size();
    return s;
  endfunction

  function automatic out_item_t blank(kind_e k);
    out_item_t o;
    o = '0;
    o.kind = k;
    return o;
  endfunction

  task automatic clear_state();
    for (int c = 0; c < NUM_CLASSES; c++) class_q[c].delete();
    last_dst = '0;
    pkt_limit = '0;
    target_rate = '0;
    drop_total = '0;
    send_total = '0;
    byte_total = '0;
  endtask

  task automatic drop_class(int c);
    drop_total += 32'(class_q[c].size());
    class_q[c].delete();
  endtask

  task automatic sched_predict(in_item_t it);
    out_item_t step_q [$];
    out_item_t o;
    pkt_t      p;
    int        c, limit, cap, n;
    logic [63:0] budget, total_bytes, qb, pps;
    case (cmd_e'(it.command))
      CMD_ENQ: begin
        c = (it.priority_class >= NUM_CLASSES) ? NUM_CLASSES - 1 : int'(it.priority_class);
        limit = (depth_limit < STORE_DEPTH) ? int'(depth_limit) : STORE_DEPTH;
        if (it.dst_present) last_dst = it.dst_tag;
        o = blank(KIND_ENQ);
        o.out_tag = it.packet_tag;
        o.out_dst = last_dst;
        o.out_class = 3'(c);
        if (queued_sum() >= limit) begin
          for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (class_q[i].size() != 0) begin
              p = class_q[i][0];
              class_q[i].delete(0);
              o.evicted_valid = 1'b1;
              o.evicted_tag = p.tag;
              drop_total++;
              break;
            end
          end
        end
        if (queued_sum() >= limit) begin
          drop_total++;
          o.kind = KIND_DROP;
        end else begin
          p.tag = it.packet_tag;
          p.dst = last_dst;
          class_q[c].insert(class_q[c].size(), p);
        end
        step_q.insert(step_q.size(), o);
      end
      CMD_DRAIN: begin
        cap = (it.drain_max > MAX_DRAIN) ? MAX_DRAIN : int'(it.drain_max);
        if (pkt_limit > 0 && pkt_limit < 32'(cap)) cap = int'(pkt_limit);
        n = 0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
          while (class_q[k].size() != 0 && n < cap) begin
            p = class_q[k][0];
            class_q[k].delete(0);
            o = blank(KIND_SENT);
            o.out_tag = p.tag;
            o.out_dst = p.dst;
            o.out_class = 3'(k);
            step_q.insert(step_q.size(), o);
            n++;
            send_total++;
            byte_total += 64'(avg_bytes);
          end
        end
        if (n == 0) step_q.insert(step_q.size(), blank(KIND_EMPTY));
      end
      CMD_BW: begin
        target_rate = it.rate_target;
        if (it.rate_target == 0 || avg_bytes == 0) begin
          pkt_limit = '0;
        end else begin
          pps = 64'(it.rate_target) / (64'(avg_bytes) * 64'd8);
          pkt_limit = (pps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pps[31:0];
        end
        if (it.rate_target == 0) begin
          for (int k = 1; k < NUM_CLASSES; k++) drop_class(k);
        end else begin
          budget = 64'(it.rate_target) / 64;
          total_bytes = '0;
          for (int k = 1; k < NUM_CLASSES; k++)
            total_bytes += 64'(class_q[k].size()) * 64'(avg_bytes);
          if (total_bytes > budget) begin
            for (int k = NUM_CLASSES - 1; k >= 1; k--) begin
              qb = 64'(class_q[k].size()) * 64'(avg_bytes);
              if (qb <= budget) budget -= qb;
              else drop_class(k);
            end
          end
        end
        step_q.insert(step_q.size(), blank(KIND_DONE));
      end
      default: begin
        clear_state();
        step_q.insert(step_q.size(), blank(KIND_DONE));
      end
    endcase
    foreach (step_q[k]) begin
      o = step_q[k];
      o.queued_total = 11'(queued_sum());
      o.dropped_count = drop_total;
      o.sent_count = send_total;
      o.sent_byte_count = byte_total;
      o.current_target = target_rate;
      o.last = (k == step_q.size() - 1);
      expected_results.insert(expected_results.size(), o);
    end
  endtask

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] got_v);
    $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, exp_v, got_v);
    fail_count_o++;
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t e;
    if (expected_results.size() == 0) begin
      $display("%0t unexpected result transaction, got kind %0d tag %0h", $time,
               got.kind, got.out_tag);
      fail_count_o++;
      return;
    end
    e = expected_results[0];
    expected_results.delete(0);
    if (got.kind !== e.kind) report("kind", 64'(e.kind), 64'(got.kind));
    if (got.out_tag !== e.out_tag) report("out_tag", 64'(e.out_tag), 64'(got.out_tag));
    if (got.out_dst !== e.out_dst) report("out_dst", 64'(e.out_dst), 64'(got.out_dst));
    if (got.out_class !== e.out_class)
      report("out_class", 64'(e.out_class), 64'(got.out_class));
    if (got.evicted_valid !== e.evicted_valid)
      report("evicted_valid", 64'(e.evicted_valid), 64'(got.evicted_valid));
    if (got.evicted_tag !== e.evicted_tag)
      report("evicted_tag", 64'(e.evicted_tag), 64'(got.evicted_tag));
    if (got.queued_total !== e.queued_total)
      report("queued_total", 64'(e.queued_total), 64'(got.queued_total));
    if (got.dropped_count !== e.dropped_count)
      report("dropped_count", 64'(e.dropped_count), 64'(got.dropped_count));
    if (got.sent_count !== e.sent_count)
      report("sent_count", 64'(e.sent_count), 64'(got.sent_count));
    if (got.sent_byte_count !== e.sent_byte_count)
      report("sent_byte_count", e.sent_byte_count, got.sent_byte_count);
    if (got.current_target !== e.current_target)
      report("current_target", 64'(e.current_target), 64'(got.current_target));
    if (got.last !== e.last) report("last", 64'(e.last), 64'(got.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_results.delete();
      avg_bytes = AVG_RESET;
      depth_limit = DEPTH_RESET;
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        compare_result(out_item_i);
        results_seen_o++;
      end
      if (push_i && !full_i) sched_predict(in_item_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_AVG:   avg_bytes = cfg_data_i[AVG_W-1:0];
          REG_DEPTH: depth_limit = cfg_data_i[DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_results.size();
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: stimulus, clock, reset and verdict for strict_priority_packet_scheduler
// depends on sps_pkg, the scheduler RTL and sps_checker
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic quiet = 1'b0;
  int fail_count, pending, results_seen, items_sent, stall_left, idle_cycles;

  always #4 clk_i = ~clk_i;

  strict_priority_packet_scheduler DUT (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  sps_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .in_item_i, .empty_i(empty),
    .pop_i(pop), .out_item_i(out_item_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen)
  );

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      pop = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      pop = 1'b0;
    end else begin
      pop = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    in_item_i = it;
    forever begin
      @(posedge clk_i);
      if (!full) break;
      @(negedge clk_i);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    wait_drained();
    repeat (60) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic in_item_t mk(cmd_e c, logic [2:0] cls, logic [15:0] tag, logic dp,
                                  logic [15:0] dst, logic [6:0] maxp, logic [31:0] tgt);
    in_item_t it;
    it.command = c;
    it.priority_class = cls;
    it.packet_tag = tag;
    it.dst_present = dp;
    it.dst_tag = dst;
    it.drain_max = maxp;
    it.rate_target = tgt;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [95:0] raw;
    int w;
    raw = {$urandom, $urandom, $urandom};
    it = in_item_t'(raw[$bits(in_item_t)-1:0]);
    w = $urandom_range(0, 99);
    if (w < 55) begin
      it.command = CMD_ENQ;
    end else if (w < 80) begin
      it.command = CMD_DRAIN;
      if ($urandom_range(0, 3) != 0) it.drain_max = 7'($urandom_range(0, 8));
    end else if (w < 97) begin
      it.command = CMD_BW;
      case ($urandom_range(0, 3))
        0: it.rate_target = '0;
        1: it.rate_target = $urandom_range(1, 200000);
        2: it.rate_target = $urandom_range(1, 5000000);
        default: ;
      endcase
    end else begin
      it.command = CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send(rand_item());
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(mk(CMD_DRAIN, 3'd0, 16'h0, 1'b0, 16'h0, 7'd4, 32'd0));
    send(mk(CMD_ENQ, 3'd0, 16'h0000, 1'b0, 16'hFFFF, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd1, 16'hFFFF, 1'b1, 16'hFFFF, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd2, 16'h1234, 1'b0, 16'h0000, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd3, 16'h00AA, 1'b1, 16'h0000, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd4, 16'h5555, 1'b1, 16'hA5A5, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd5, 16'hAAAA, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd7, 16'h7777, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_DRAIN, 3'd0, 16'h0, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_DRAIN, 3'd0, 16'h0, 1'b0, 16'h0, 7'd2, 32'd0));
    send(mk(CMD_BW, 3'd0, 16'h0, 1'b0, 16'h0, 7'd0, 32'hFFFF_FFFF));
    send(mk(CMD_DRAIN, 3'd0, 16'h0, 1'b0, 16'h0, 7'd127, 32'd0));
    send(mk(CMD_ENQ, 3'd3, 16'h0101, 1'b1, 16'h0202, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd4, 16'h0303, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_BW, 3'd0, 16'h0, 1'b0, 16'h0, 7'd0, 32'd19200));
    send(mk(CMD_ENQ, 3'd1, 16'h0404, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_BW, 3'd0, 16'h0, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_ENQ, 3'd0, 16'h0505, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_DRAIN, 3'd0, 16'h0, 1'b0, 16'h0, 7'd64, 32'd0));
    send(mk(CMD_CLEAR, 3'd0, 16'h0, 1'b0, 16'h0, 7'd0, 32'd0));
    send(mk(CMD_DRAIN, 3'd0, 16'h0, 1'b0, 16'h0, 7'd65, 32'd0));

    write_reg(REG_AVG, 32'd1);
    write_reg(REG_DEPTH, 32'd4);
    run_random(80);

    write_reg(REG_AVG, 32'hFFFF_FFFF);
    write_reg(REG_DEPTH, 32'd1024);
    run_random(40);
    wait_drained();
    run_random(40);

    write_reg(REG_AVG, 32'd0);
    write_reg(REG_DEPTH, 32'd0);
    run_random(40);

    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(REG_AVG, 32'd300);
    write_reg(REG_DEPTH, 32'h0000_07FF);
    run_random(80);

    write_reg(REG_AVG, 32'd1200);
    write_reg(REG_DEPTH, 32'd16);
    quiet = 1'b1;
    run_random(100);

    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("sent %0d commands over six register settings, checked %0d results",
             items_sent, results_seen);
    $display("covered eviction, tail drop, strict-priority drains, rate trims and clears");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_div.sv
rtl/sps_outq.sv
rtl/sps_back.sv
rtl/strict_priority_packet_scheduler.sv
tb/sps_checker.sv
tb/tb_top.sv
